>>> hw/rtl/cp565_pkg.sv
// Shared types and constants for the camera byte to RGB565 converter.
package cp565_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_ROW_STRIDE   = 2'd2;

    // Pixel format codes (code 3 is unused: bytes advance, no pixels)
    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_YUYV   = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;

    // Register reset values
    localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_GRAY8;
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd320;
    localparam logic [13:0] RST_ROW_STRIDE   = 14'd0;

    // Internal row position width: covers twice the largest frame width
    localparam int POS_W = 15;

    // BT.601 integer coefficients
    localparam logic signed [19:0] K_Y     = 20'sd298;
    localparam logic signed [19:0] K_RV    = 20'sd409;
    localparam logic signed [19:0] K_GU    = 20'sd100;
    localparam logic signed [19:0] K_GV    = 20'sd208;
    localparam logic signed [19:0] K_BU    = 20'sd516;
    localparam logic signed [19:0] K_ROUND = 20'sd128;
    localparam logic signed [9:0]  Y_OFFSET = 10'sd16;
    localparam logic signed [9:0]  C_OFFSET = 10'sd128;
    localparam logic [7:0]         CHROMA_NEUTRAL = 8'd128;
    localparam logic [7:0]         CHAN_MAX = 8'd255;

    // What the decode stage hands to the conversion stage
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GRAY,
        KIND_RGB,
        KIND_PAIR
    } item_kind_t;

    // One result item
    typedef struct packed {
        logic [15:0] pixel;
        logic        row_end;
        logic        run_last;
    } result_t;

endpackage

>>> hw/rtl/cp565_yuv.sv
// BT.601 integer YUV to RGB565 pixel conversion with channel clamping.
module cp565_yuv
    import cp565_pkg::*;
(
    input  logic [7:0]  y,
    input  logic [7:0]  u,
    input  logic [7:0]  v,
    output logic [15:0] pixel
);

    logic signed [9:0]  c, d, e;
    logic signed [19:0] r_sum, g_sum, b_sum;
    logic [7:0]         r, g, b;

    function automatic logic [7:0] clamp8(input logic signed [19:0] sum);
        logic [7:0] res;
        if (sum[19]) begin
            res = 8'd0;
        end else if (sum[18:16] != 3'd0) begin
            res = CHAN_MAX;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

    always_comb begin
        c = $signed({2'b00, y}) - Y_OFFSET;
        d = $signed({2'b00, u}) - C_OFFSET;
        e = $signed({2'b00, v}) - C_OFFSET;
        r_sum = K_Y * 20'(c) + K_RV * 20'(e) + K_ROUND;
        g_sum = K_Y * 20'(c) - K_GU * 20'(d) - K_GV * 20'(e) + K_ROUND;
        b_sum = K_Y * 20'(c) + K_BU * 20'(d) + K_ROUND;
        r = clamp8(r_sum);
        g = clamp8(g_sum);
        b = clamp8(b_sum);
        pixel = {r[7:3], g[7:2], b[7:3]};
    end

endmodule

>>> hw/rtl/camera_pixel_to_rgb565.sv
// Camera byte stream to RGB565 pixel converter, top level.
//
// Takes raw frame bytes, one item per clock, and emits RGB565 pixels. The
// pixel_format register picks GRAY8 (a byte is luma with neutral chroma),
// YUYV (Y0 U Y1 V gives two pixels, integer BT.601 with clamping) or RGB565
// passthrough (two bytes, low byte first). Bytes past the active width of a
// row are skipped using row_stride (zero means width times bytes per pixel);
// in YUYV an odd last pixel of a row is dropped. s_tuser marks the first
// byte of a frame. Each byte is decoded as it is accepted, converted in the
// next cycle and pushed into a four-entry output queue. A byte is taken
// every clock while the queue has room for two results; the only stall
// comes from m_tready. A YUYV group produces two results, which leave the
// queue one at a time. m_tlast flags the last pixel of a row; m_tuser flags
// the last result caused by one input byte. Configuration writes must be
// made while the block is idle.
module camera_pixel_to_rgb565
    import cp565_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_wdata,
    // Input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] start_of_frame
    // Output pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] pixel_rgb565
    output logic        m_tlast,    // row_end
    output logic        m_tuser     // [0] run_last
);

    localparam logic [13:0] WIDTH_CAP = 14'(MAX_WIDTH);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [1:0]  fmt_reg;
    logic [12:0] width_cfg_reg;
    logic [13:0] stride_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg        <= RST_PIXEL_FORMAT;
            width_cfg_reg  <= RST_FRAME_WIDTH;
            stride_cfg_reg <= RST_ROW_STRIDE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PIXEL_FORMAT: fmt_reg        <= cfg_wdata[1:0];
                CFG_FRAME_WIDTH:  width_cfg_reg  <= cfg_wdata[12:0];
                CFG_ROW_STRIDE:   stride_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Row geometry, derived from the registers
    // ---------------------------------------------------------------------
    logic [13:0]      width;
    logic [POS_W-1:0] width_p;
    logic [POS_W-1:0] active;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] stride;
    logic [POS_W-1:0] stride_base;
    logic             two_bpp;

    always_comb begin
        width   = ({1'b0, width_cfg_reg} > WIDTH_CAP) ? WIDTH_CAP : {1'b0, width_cfg_reg};
        width_p = POS_W'(width);
        two_bpp = (fmt_reg == FMT_YUYV) || (fmt_reg == FMT_RGB565);
        active  = two_bpp ? POS_W'({width, 1'b0}) : width_p;
        // YUYV covers whole pairs only
        span    = POS_W'({width[13:1], 2'b00});
        stride_base = (stride_cfg_reg != 14'd0) ? POS_W'(stride_cfg_reg) : active;
        if (stride_base < active) begin
            stride_base = active;
        end
        stride = (stride_base == '0) ? POS_W'(1) : stride_base;
    end

    // ---------------------------------------------------------------------
    // Decode stage: runs on each accepted byte
    // ---------------------------------------------------------------------
    logic [13:0] col_reg, col_next;
    logic [7:0]  held_first_reg, held_first_next;
    logic [7:0]  held_second_reg, held_second_next;
    logic [7:0]  held_third_reg, held_third_next;

    logic [POS_W-1:0] pos_raw, pos, pos_inc;
    logic             accept;

    item_kind_t  s1_kind_reg, s1_kind_next;
    logic [7:0]  s1_y0_reg, s1_y0_next;
    logic [7:0]  s1_y1_reg, s1_y1_next;
    logic [7:0]  s1_u_reg, s1_u_next;
    logic [7:0]  s1_v_reg, s1_v_next;
    logic        s1_row_end_reg, s1_row_end_next;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        pos_raw = s_tuser ? '0 : POS_W'(col_reg);
        // Column beyond the stride (geometry changed mid row) restarts the row
        pos     = (pos_raw >= stride) ? '0 : pos_raw;
        pos_inc = pos + POS_W'(1);

        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        held_third_next  = held_third_reg;
        s1_kind_next     = KIND_NONE;
        s1_y0_next       = s_tdata;
        s1_y1_next       = s_tdata;
        s1_u_next        = CHROMA_NEUTRAL;
        s1_v_next        = CHROMA_NEUTRAL;
        s1_row_end_next  = 1'b0;
        col_next         = col_reg;

        if (accept) begin
            col_next = (pos_inc >= stride) ? 14'd0 : pos_inc[13:0];
            case (fmt_reg)
                FMT_GRAY8: begin
                    if (pos < width_p) begin
                        s1_kind_next    = KIND_GRAY;
                        s1_row_end_next = (pos == width_p - POS_W'(1));
                    end
                end
                FMT_RGB565: begin
                    if (pos < active) begin
                        if (!pos[0]) begin
                            held_first_next = s_tdata;
                        end else begin
                            s1_kind_next    = KIND_RGB;
                            s1_y0_next      = held_first_reg;
                            s1_y1_next      = s_tdata;
                            s1_row_end_next = (pos == active - POS_W'(1));
                        end
                    end
                end
                FMT_YUYV: begin
                    if (pos < span) begin
                        case (pos[1:0])
                            2'd0: held_first_next  = s_tdata;
                            2'd1: held_second_next = s_tdata;
                            2'd2: held_third_next  = s_tdata;
                            default: begin
                                s1_kind_next    = KIND_PAIR;
                                s1_y0_next      = held_first_reg;
                                s1_y1_next      = held_third_reg;
                                s1_u_next       = held_second_reg;
                                s1_v_next       = s_tdata;
                                s1_row_end_next = (pos == span - POS_W'(1));
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            held_third_reg  <= '0;
            s1_kind_reg     <= KIND_NONE;
        end else begin
            col_reg         <= col_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            held_third_reg  <= held_third_next;
            s1_kind_reg     <= s1_kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_y0_reg      <= s1_y0_next;
        s1_y1_reg      <= s1_y1_next;
        s1_u_reg       <= s1_u_next;
        s1_v_reg       <= s1_v_next;
        s1_row_end_reg <= s1_row_end_next;
    end

    // ---------------------------------------------------------------------
    // Conversion stage: two converters, one per pixel of a YUYV pair
    // ---------------------------------------------------------------------
    logic [15:0] px0, px1;
    result_t     push0, push1;
    logic [1:0]  push_n;

    cp565_yuv u_conv0 (
        .y     (s1_y0_reg),
        .u     (s1_u_reg),
        .v     (s1_v_reg),
        .pixel (px0)
    );

    cp565_yuv u_conv1 (
        .y     (s1_y1_reg),
        .u     (s1_u_reg),
        .v     (s1_v_reg),
        .pixel (px1)
    );

    always_comb begin
        push1 = '{pixel: px1, row_end: s1_row_end_reg, run_last: 1'b1};
        case (s1_kind_reg)
            KIND_GRAY: begin
                push0  = '{pixel: px0, row_end: s1_row_end_reg, run_last: 1'b1};
                push_n = 2'd1;
            end
            KIND_RGB: begin
                push0  = '{pixel: {s1_y1_reg, s1_y0_reg}, row_end: s1_row_end_reg,
                           run_last: 1'b1};
                push_n = 2'd1;
            end
            KIND_PAIR: begin
                // first pixel of the pair never ends the row or the byte's run
                push0  = '{pixel: px0, row_end: 1'b0, run_last: 1'b0};
                push_n = 2'd2;
            end
            default: begin
                push0  = '{pixel: px0, row_end: 1'b0, run_last: 1'b0};
                push_n = 2'd0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Output queue: four items, up to two pushed and one popped per cycle
    // ---------------------------------------------------------------------
    result_t    q_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    result_t    head;

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = head.pixel;
    assign m_tlast  = head.row_end;
    assign m_tuser  = head.run_last;
    assign pop      = m_tvalid && m_tready;

    // Room for two more results after whatever the conversion stage pushes
    assign s_tready = (cnt_reg + 3'(push_n)) <= 3'd2;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        cnt_next    = cnt_reg + 3'(push_n) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

endmodule
